@@ rtl/core/trs_aff_pkg.sv @@
// Shared widths, constants and pipeline stage types of the TRS-to-affine block.
`default_nettype none

package trs_aff_pkg;

  localparam int QW        = 16;  // quaternion component, Q1.15
  localparam int SW        = 16;  // axis scale, Q8.8
  localparam int PW        = 32;  // position and matrix entry, Q16.16
  localparam int PRODW     = 2 * QW;         // quaternion product, Q.30
  localparam int ENTW      = PRODW + 2;      // rotation entry, Q.30 with headroom
  localparam int MULW      = ENTW + SW;      // scaled entry, Q.38
  localparam int NARROW_SH = 22;             // Q.38 -> Q16.16
  localparam int IN_W      = 4 * QW + 3 * SW + 3 * PW;
  localparam int OUT_W     = 12 * PW;

  typedef logic signed [QW-1:0]    quat_t;
  typedef logic signed [SW-1:0]    scale_t;
  typedef logic signed [PW-1:0]    fix_t;
  typedef logic signed [PRODW-1:0] prod_t;
  typedef logic signed [ENTW-1:0]  ent_t;
  typedef logic signed [MULW-1:0]  mul_t;

  localparam ent_t Q30_ONE  = ENTW'(2 ** 30);
  localparam mul_t RND_HALF = MULW'(2 ** (NARROW_SH - 1));
  localparam mul_t FIX_MAX  = MULW'(2 ** (PW - 1) - 1);
  localparam mul_t FIX_MIN  = -FIX_MAX - MULW'(1);

  // Input item; last field sits in the lowest bits.
  typedef struct packed {
    fix_t   pos_z;
    fix_t   pos_y;
    fix_t   pos_x;
    scale_t scale_z;
    scale_t scale_y;
    scale_t scale_x;
    quat_t  quat_w;
    quat_t  quat_z;
    quat_t  quat_y;
    quat_t  quat_x;
  } in_item_t;

  // Result item; last field sits in the lowest bits.
  typedef struct packed {
    fix_t trans_z;
    fix_t trans_y;
    fix_t trans_x;
    fix_t col2_row2;
    fix_t col2_row1;
    fix_t col2_row0;
    fix_t col1_row2;
    fix_t col1_row1;
    fix_t col1_row0;
    fix_t col0_row2;
    fix_t col0_row1;
    fix_t col0_row0;
  } out_item_t;

  // After the product stage.
  typedef struct packed {
    fix_t   pos_z;
    fix_t   pos_y;
    fix_t   pos_x;
    scale_t scale_z;
    scale_t scale_y;
    scale_t scale_x;
    prod_t  xx;
    prod_t  yy;
    prod_t  zz;
    prod_t  xy;
    prod_t  xz;
    prod_t  yz;
    prod_t  wx;
    prod_t  wy;
    prod_t  wz;
  } s1_t;

  // After the entry stage; ent index is col * 3 + row.
  typedef struct packed {
    fix_t           pos_z;
    fix_t           pos_y;
    fix_t           pos_x;
    scale_t         scale_z;
    scale_t         scale_y;
    scale_t         scale_x;
    ent_t [8:0]     ent;
  } s2_t;

  // After the scale multiply; mul index is col * 3 + row.
  typedef struct packed {
    fix_t           pos_z;
    fix_t           pos_y;
    fix_t           pos_x;
    mul_t [8:0]     mul;
  } s3_t;

endpackage

`default_nettype wire

@@ rtl/core/trs_aff_quat_prod.sv @@
// Stage 1: the nine quaternion products, registered.
`default_nettype none

module trs_aff_quat_prod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trs_aff_pkg::in_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trs_aff_pkg::s1_t      out_data
);
  import trs_aff_pkg::*;

  logic vld_r;
  s1_t  data_r;
  s1_t  data_nxt;

  always_comb begin
    data_nxt.pos_x   = in_data.pos_x;
    data_nxt.pos_y   = in_data.pos_y;
    data_nxt.pos_z   = in_data.pos_z;
    data_nxt.scale_x = in_data.scale_x;
    data_nxt.scale_y = in_data.scale_y;
    data_nxt.scale_z = in_data.scale_z;
    data_nxt.xx = in_data.quat_x * in_data.quat_x;
    data_nxt.yy = in_data.quat_y * in_data.quat_y;
    data_nxt.zz = in_data.quat_z * in_data.quat_z;
    data_nxt.xy = in_data.quat_x * in_data.quat_y;
    data_nxt.xz = in_data.quat_x * in_data.quat_z;
    data_nxt.yz = in_data.quat_y * in_data.quat_z;
    data_nxt.wx = in_data.quat_w * in_data.quat_x;
    data_nxt.wy = in_data.quat_w * in_data.quat_y;
    data_nxt.wz = in_data.quat_w * in_data.quat_z;
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/core/trs_aff_rot_entry.sv @@
// Stage 2: rotation matrix entries in Q.30 from the quaternion products.
`default_nettype none

module trs_aff_rot_entry (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  trs_aff_pkg::s1_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output trs_aff_pkg::s2_t out_data
);
  import trs_aff_pkg::*;

  logic vld_r;
  s2_t  data_r;
  s2_t  data_nxt;

  // 1 - 2(a + b)
  function automatic ent_t one_minus(input prod_t a, input prod_t b);
    ent_t ea;
    ent_t eb;
    ea = ENTW'(a);
    eb = ENTW'(b);
    return Q30_ONE - ((ea + eb) <<< 1);
  endfunction

  // 2(a + b)
  function automatic ent_t twice_sum(input prod_t a, input prod_t b);
    ent_t ea;
    ent_t eb;
    ea = ENTW'(a);
    eb = ENTW'(b);
    return (ea + eb) <<< 1;
  endfunction

  // 2(a - b)
  function automatic ent_t twice_diff(input prod_t a, input prod_t b);
    ent_t ea;
    ent_t eb;
    ea = ENTW'(a);
    eb = ENTW'(b);
    return (ea - eb) <<< 1;
  endfunction

  always_comb begin
    data_nxt.pos_x   = in_data.pos_x;
    data_nxt.pos_y   = in_data.pos_y;
    data_nxt.pos_z   = in_data.pos_z;
    data_nxt.scale_x = in_data.scale_x;
    data_nxt.scale_y = in_data.scale_y;
    data_nxt.scale_z = in_data.scale_z;
    data_nxt.ent[0]  = one_minus(in_data.yy, in_data.zz);
    data_nxt.ent[1]  = twice_sum(in_data.xy, in_data.wz);
    data_nxt.ent[2]  = twice_diff(in_data.xz, in_data.wy);
    data_nxt.ent[3]  = twice_diff(in_data.xy, in_data.wz);
    data_nxt.ent[4]  = one_minus(in_data.xx, in_data.zz);
    data_nxt.ent[5]  = twice_sum(in_data.yz, in_data.wx);
    data_nxt.ent[6]  = twice_sum(in_data.xz, in_data.wy);
    data_nxt.ent[7]  = twice_diff(in_data.yz, in_data.wx);
    data_nxt.ent[8]  = one_minus(in_data.xx, in_data.yy);
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/core/trs_aff_col_scale.sv @@
// Stage 3: multiply each rotation column by its axis scale (Q.38).
`default_nettype none

module trs_aff_col_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  trs_aff_pkg::s2_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output trs_aff_pkg::s3_t out_data
);
  import trs_aff_pkg::*;

  logic vld_r;
  s3_t  data_r;
  s3_t  data_nxt;

  always_comb begin
    ent_t   ent;
    scale_t sc;
    mul_t   prod;
    data_nxt.pos_x = in_data.pos_x;
    data_nxt.pos_y = in_data.pos_y;
    data_nxt.pos_z = in_data.pos_z;
    for (int i = 0; i < 9; i++) begin
      ent = in_data.ent[i];
      case (i / 3)
        0:       sc = in_data.scale_x;
        1:       sc = in_data.scale_y;
        default: sc = in_data.scale_z;
      endcase
      prod = ent * sc;
      data_nxt.mul[i] = prod;
    end
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/core/trs_aff_round_sat.sv @@
// Stage 4: round Q.38 to Q16.16 (half up), saturate, and form the result item.
`default_nettype none

module trs_aff_round_sat (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  trs_aff_pkg::s3_t       in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output trs_aff_pkg::out_item_t out_data
);
  import trs_aff_pkg::*;

  logic      vld_r;
  out_item_t data_r;
  out_item_t data_nxt;

  function automatic fix_t round_sat(input mul_t v);
    mul_t sh;
    sh = (v + RND_HALF) >>> NARROW_SH;
    if (sh > FIX_MAX) begin
      return FIX_MAX[PW-1:0];
    end else if (sh < FIX_MIN) begin
      return FIX_MIN[PW-1:0];
    end
    return sh[PW-1:0];
  endfunction

  always_comb begin
    data_nxt.col0_row0 = round_sat(in_data.mul[0]);
    data_nxt.col0_row1 = round_sat(in_data.mul[1]);
    data_nxt.col0_row2 = round_sat(in_data.mul[2]);
    data_nxt.col1_row0 = round_sat(in_data.mul[3]);
    data_nxt.col1_row1 = round_sat(in_data.mul[4]);
    data_nxt.col1_row2 = round_sat(in_data.mul[5]);
    data_nxt.col2_row0 = round_sat(in_data.mul[6]);
    data_nxt.col2_row1 = round_sat(in_data.mul[7]);
    data_nxt.col2_row2 = round_sat(in_data.mul[8]);
    data_nxt.trans_x   = in_data.pos_x;
    data_nxt.trans_y   = in_data.pos_y;
    data_nxt.trans_z   = in_data.pos_z;
  end

  assign in_ready = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/core/trs_to_affine_matrix.sv @@
// Top level: quaternion, scale and position to the upper 3x4 affine matrix.
// Pipeline: products, entries, scale multiply and round/saturate, one register each;
//   a result waits in the output register while out_tready is low.
// Throughput: one item per cycle while out_tready is high; each stage holds one item and advances
//   whenever it is empty or the stage after it advances.
// Reset: synchronous active-low rst_n clears the stage valid bits only.
`default_nettype none

module trs_to_affine_matrix (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48],
  //   scale_x[79:64], scale_y[95:80], scale_z[111:96], pos_x[143:112],
  //   pos_y[175:144], pos_z[207:176]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [207:0] in_tdata,
  // out_tdata: col0_row0[31:0], col0_row1[63:32], col0_row2[95:64],
  //   col1_row0[127:96], col1_row1[159:128], col1_row2[191:160],
  //   col2_row0[223:192], col2_row1[255:224], col2_row2[287:256],
  //   trans_x[319:288], trans_y[351:320], trans_z[383:352]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [383:0] out_tdata
);
  import trs_aff_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;

  // Stage-to-stage handshake and payload.
  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;

  assign in_item = in_item_t'(in_tdata);

  // Nine 16x16 products; scale and position ride along.
  trs_aff_quat_prod u_quat_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_item),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Combine products into the nine rotation entries.
  trs_aff_rot_entry u_rot_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // Scale each column by its axis scale.
  trs_aff_col_scale u_col_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // Round to Q16.16, saturate, and hold the result in the output register.
  trs_aff_round_sat u_round_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_item)
  );

  assign out_tdata = OUT_W'(out_item);

  // A consumer that takes results never stalls the input.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is being drained");

  // An empty output register always leaves room upstream.
  a_room_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // No result appears right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // Stage 3, when full and stalled, keeps its item.
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid && !s3_ready) |=> s3_valid && $stable(s3_data))
    else $error("stage 3 item lost during stall");

endmodule

`default_nettype wire
